// ===== hw/rtl/ced_pkg.sv =====
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, character codes and the pad count function of the
// capability escape decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int unsigned DELAY_W   = 20;
    localparam int unsigned PAD_W     = 7;
    localparam int unsigned SPEED_W   = 4;
    localparam logic [DELAY_W-1:0] DELAY_MAX = 20'hF_FFFF;
    localparam logic [PAD_W-1:0]   PAD_CAP   = 7'd100;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CARET_MASK = 8'h1F;

    // configuration register indexes
    localparam logic CFG_LINE_SPEED = 1'b0;
    localparam logic CFG_FULL_SPEED = 1'b1;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             end_of_string;
        logic [PAD_W-1:0] pad_count;
        logic             last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;     // results caused by this character, 0..2
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    // Halve once per speed step below full speed, add one, cap; a zero delay gives zero.
    function automatic logic [PAD_W-1:0] pad_calc(
        input logic [DELAY_W-1:0] delay,
        input logic [SPEED_W-1:0] line_speed,
        input logic [SPEED_W-1:0] full_speed
    );
        logic [SPEED_W-1:0] shamt;
        logic [DELAY_W-1:0] shifted;
        logic [DELAY_W:0]   inc;
        shamt   = (line_speed < full_speed) ? (full_speed - line_speed) : '0;
        shifted = delay >> shamt;
        inc     = {1'b0, shifted} + {{DELAY_W{1'b0}}, 1'b1};
        if (delay == '0) begin
            return '0;
        end
        if (inc > {{(DELAY_W+1-PAD_W){1'b0}}, PAD_CAP}) begin
            return PAD_CAP;
        end
        return inc[PAD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ced_decode.sv =====
// ----------------------------------------------------------------------------
// ced_decode
// Decode state, speed registers and the single-pass character decoder that
// yields up to two results per character.
// ----------------------------------------------------------------------------
module ced_decode
    import ced_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [SPEED_W-1:0]  i_cfg_wdata,
    input  logic                i_accept,
    input  logic [7:0]          i_char,
    output t_dec_out            o_dec
);

    localparam logic [2:0] MODE_DIGITS = 3'd0;
    localparam logic [2:0] MODE_BODY   = 3'd1;
    localparam logic [2:0] MODE_CARET  = 3'd2;
    localparam logic [2:0] MODE_BSL    = 3'd3;
    localparam logic [2:0] MODE_OCT_B  = 3'd4;
    localparam logic [2:0] MODE_OCT_C  = 3'd5;

    logic [SPEED_W-1:0] r_line_speed;
    logic [SPEED_W-1:0] r_full_speed;
    logic [2:0]         r_mode, n_mode;
    logic [DELAY_W-1:0] r_acc, n_acc;
    logic [7:0]         r_oct, n_oct;

    logic               is_digit;
    logic [7:0]         digit;
    logic [DELAY_W+3:0] acc_prod;
    t_result            term_res;
    t_result            char_res;
    logic               body_term;
    logic               body_none;
    logic [2:0]         body_mode;
    logic [7:0]         esc_byte;
    logic [7:0]         oct_shift;

    assign is_digit  = i_char inside {[CH_ZERO:CH_NINE]};
    assign digit     = i_char - CH_ZERO;
    assign oct_shift = {r_oct[4:0], 3'b000};
    assign acc_prod  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                     + {{(DELAY_W-4){1'b0}}, digit};

    assign term_res = '{out_byte: 8'd0, end_of_string: 1'b1,
                        pad_count: pad_calc(r_acc, r_line_speed, r_full_speed),
                        last_of_run: 1'b1};
    assign char_res = '{out_byte: i_char, end_of_string: 1'b0,
                        pad_count: '0, last_of_run: 1'b1};

    // body-mode reading of the current character
    always_comb begin
        body_term = i_char inside {CH_NUL, CH_COLON};
        body_none = i_char inside {CH_CARET, CH_BSL};
        case (i_char)
            CH_CARET: body_mode = MODE_CARET;
            CH_BSL:   body_mode = MODE_BSL;
            default:  body_mode = MODE_BODY;
        endcase
    end

    always_comb begin
        case (i_char)
            CH_UPPER_E: esc_byte = CH_ESC;
            CH_LOWER_N: esc_byte = CH_LF;
            CH_LOWER_R: esc_byte = CH_CR;
            CH_LOWER_T: esc_byte = CH_TAB;
            CH_LOWER_B: esc_byte = CH_BS;
            CH_LOWER_F: esc_byte = CH_FF;
            default:    esc_byte = i_char;
        endcase
    end

    always_comb begin
        logic term;
        term         = 1'b0;
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_oct        = r_oct;
        o_dec.count  = 2'd0;
        o_dec.res0   = char_res;
        o_dec.res1   = char_res;
        case (r_mode)
            MODE_BODY: begin
                n_mode = body_mode;
                term   = body_term;
                if (!body_term && !body_none) begin
                    o_dec.count = 2'd1;
                end
            end
            MODE_CARET: begin
                if (i_char == CH_NUL) begin
                    term = 1'b1;
                end else begin
                    n_mode = MODE_BODY;
                    o_dec.count = 2'd1;
                    o_dec.res0.out_byte = i_char & CARET_MASK;
                end
            end
            MODE_BSL: begin
                if (i_char == CH_NUL) begin
                    term = 1'b1;
                end else if (is_digit) begin
                    n_oct  = digit;
                    n_mode = MODE_OCT_B;
                end else begin
                    n_mode = MODE_BODY;
                    o_dec.count = 2'd1;
                    o_dec.res0.out_byte = esc_byte;
                end
            end
            MODE_OCT_B: begin
                if (i_char == CH_NUL) begin
                    term = 1'b1;
                end else begin
                    n_oct  = oct_shift | digit;
                    n_mode = MODE_OCT_C;
                end
            end
            MODE_OCT_C: begin
                n_oct = 8'd0;
                o_dec.res0.out_byte = r_oct;
                if (is_digit) begin
                    n_mode = MODE_BODY;
                    o_dec.count = 2'd1;
                    o_dec.res0.out_byte = oct_shift | digit;
                end else begin
                    // octal byte first, then the character read as body
                    n_mode = body_mode;
                    if (body_none) begin
                        o_dec.count = 2'd1;
                    end else begin
                        o_dec.count = 2'd2;
                        o_dec.res0.last_of_run = 1'b0;
                        o_dec.res1 = body_term ? term_res : char_res;
                        if (body_term) begin
                            n_mode = MODE_DIGITS;
                            n_acc  = '0;
                        end
                    end
                end
            end
            default: begin
                if (is_digit) begin
                    n_acc = (acc_prod[DELAY_W+3:DELAY_W] != 4'd0) ? DELAY_MAX
                                                                   : acc_prod[DELAY_W-1:0];
                end else begin
                    n_mode = body_mode;
                    term   = body_term;
                    if (!body_term && !body_none) begin
                        o_dec.count = 2'd1;
                    end
                end
            end
        endcase
        if (term) begin
            n_mode      = MODE_DIGITS;
            n_acc       = '0;
            n_oct       = 8'd0;
            o_dec.count = 2'd1;
            o_dec.res0  = term_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_speed <= 4'd13;
            r_full_speed <= 4'd13;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LINE_SPEED) begin
                r_line_speed <= i_cfg_wdata;
            end else begin
                r_full_speed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DIGITS;
            r_acc  <= '0;
            r_oct  <= 8'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_oct  <= n_oct;
        end
    end

    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= DELAY_MAX)
        else $error("delay accumulator above saturation value");

    a_two_only_octal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.count == 2'd2) |-> (r_mode == MODE_OCT_C))
        else $error("two results outside the octal third-digit mode");

    a_term_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_dec.count != 2'd0 &&
         ((o_dec.count == 2'd1 && o_dec.res0.end_of_string) ||
          (o_dec.count == 2'd2 && o_dec.res1.end_of_string)))
        |=> (r_mode == MODE_DIGITS && r_acc == '0 && r_oct == 8'd0))
        else $error("state not cleared after terminator");

endmodule

// ===== hw/rtl/ced_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ced_out_fifo
// Four-entry result queue; takes up to two results and gives one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module ced_out_fifo
    import ced_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_dec_out  i_dec,
    output logic      o_room2,
    output logic      o_valid,
    input  logic      i_pop_ready,
    output t_result   o_head
);

    t_result    r_mem [4];
    logic [1:0] r_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_count;
    logic [1:0] push_cnt;
    logic       pop;

    assign push_cnt = i_push ? i_dec.count : 2'd0;
    assign pop      = (r_count != 3'd0) && i_pop_ready;
    assign o_valid  = (r_count != 3'd0);
    assign o_room2  = (r_count <= 3'd2);
    assign o_head   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_dec.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wptr  <= r_wptr + push_cnt;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= r_count + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

endmodule

// ===== hw/rtl/capability_escape_decoder_core.sv =====
// ----------------------------------------------------------------------------
// capability_escape_decoder_core
// Capability string escape decoder: one character in, up to two decoded
// results out on a stream interface.
// ----------------------------------------------------------------------------
// One character is taken per cycle while s_axis_tready is high. Each character
// is decoded combinationally and its results (none, one, or two for an octal
// escape closed by a non-digit) go into a four-entry output queue; a character
// is accepted whenever at least two queue entries are free, so with the output
// side ready the block runs at one character per clock, and after a two-result
// character the queue holds the extra result until the output side takes it.
// Results are registered in the output queue before they appear on the output.
module capability_escape_decoder_core
    import ced_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [3:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] in_char
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // [7:0] out_byte, [14:8] pad_count, [15] zero
    output logic         m_axis_tuser,   // [0] end_of_string
    output logic         m_axis_tlast
);

    t_dec_out dec;
    t_result  head;
    logic     room2;
    logic     accept;

    assign s_axis_tready = room2;
    assign accept        = s_axis_tvalid && room2;

    ced_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_char      (s_axis_tdata),
        .o_dec       (dec)
    );

    ced_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_dec       (dec),
        .o_room2     (room2),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_head      (head)
    );

    assign m_axis_tdata = {1'b0, head.pad_count, head.out_byte};
    assign m_axis_tuser = head.end_of_string;
    assign m_axis_tlast = head.last_of_run;

endmodule
